/* hdl/tdq_pkg.sv */
// Shared types and constants for the timer deadline queue.
// No dependencies; compile before the interfaces and the core.
package tdq_pkg;

  localparam int TIME_W        = 48;
  localparam int ID_W          = 16;
  localparam int QUEUE_DEPTH_D = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int POP_W         = $clog2(MAX_RESULTS + 1);

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_EXPIRE = 1'b1
  } tdq_action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_EXP_RD,
    ST_EXP_CMP,
    ST_FINISH
  } tdq_state_t;

  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [ID_W-1:0]   id;
  } tdq_entry_t;

  typedef struct packed {
    logic [ID_W-1:0]   expired_id;
    logic              expired_valid;
    logic              last;
    logic              new_earliest;
    logic              deadline_valid;
    logic [TIME_W-1:0] next_deadline;
    logic              insert_dropped;
  } tdq_result_t;

endpackage

/* hdl/tdq_cmd_if.sv */
// Command channel of the timer deadline queue: valid/ready plus one command.
// Depends on tdq_pkg.
interface tdq_cmd_if;
  import tdq_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [TIME_W-1:0] time_value;
  logic [ID_W-1:0]   timer_id;

  modport source (output valid, action, time_value, timer_id, input ready);
  modport sink   (input valid, action, time_value, timer_id, output ready);
endinterface

/* hdl/tdq_rsp_if.sv */
// Result channel of the timer deadline queue: valid/ready plus one result.
// Depends on tdq_pkg.
interface tdq_rsp_if;
  import tdq_pkg::*;

  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   expired_id;
  logic              expired_valid;
  logic              last;
  logic              new_earliest;
  logic              deadline_valid;
  logic [TIME_W-1:0] next_deadline;
  logic              insert_dropped;

  modport source (output valid, expired_id, expired_valid, last, new_earliest,
                  deadline_valid, next_deadline, insert_dropped, input ready);
  modport sink   (input valid, expired_id, expired_valid, last, new_earliest,
                  deadline_valid, next_deadline, insert_dropped, output ready);
endinterface

/* hdl/timer_deadline_queue_core.sv */
// Timer deadline queue core: sorted store of (deadline, id) pairs.
// Depends on tdq_pkg, tdq_cmd_if and tdq_rsp_if.
//
// Usage:
//   cmd carries one command per beat: insert (deadline in time_value, id in
//   timer_id) or expire (current time in time_value). rsp returns results;
//   every command ends with exactly one beat that has last set.
//   An insert gives one beat: new_earliest, insert_dropped when the store
//   is full, and the earliest pending deadline. An expire gives one beat per
//   popped timer (at most 16 per command), or a single beat with no id when
//   nothing is due; the last beat carries the next pending deadline.
// Operation:
//   The store is a circular buffer in a single-port-read, single-port-write
//   memory, kept sorted by an insertion walk from the tail. Each compare
//   takes a read state and then a compare state: an insert walks one entry
//   per read/compare pair, an expire pops one timer per pair, and a refused
//   insert goes straight to the finish state.
//   cmd.ready is high only while the core is idle.
// Reset:
//   rst (synchronous) empties the queue and drops any pending result beat.
// Backpressure:
//   The result register holds its beat while rsp.ready is low; an expire
//   walk and the finish state stall until the register frees up.
module timer_deadline_queue_core #(
  parameter int QUEUE_DEPTH = tdq_pkg::QUEUE_DEPTH_D
) (
  input  logic      clk,
  input  logic      rst,
  tdq_cmd_if.sink   cmd,
  tdq_rsp_if.source rsp
);
  import tdq_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [POP_W-1:0] POP_MAX   = POP_W'(MAX_RESULTS);

  function automatic logic [IDX_W-1:0] slot_addr(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] ofs);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(ofs);
    if (sum >= DEPTH_SUM) begin
      sum = sum - DEPTH_SUM;
    end
    return sum[IDX_W-1:0];
  endfunction

  tdq_entry_t store [QUEUE_DEPTH];

  tdq_state_t        state, state_next;
  logic [IDX_W-1:0]  head, head_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  slot, slot_next;
  logic [TIME_W-1:0] tv, tv_next;
  logic [ID_W-1:0]   tid, tid_next;
  logic [POP_W-1:0]  n_pop, n_pop_next;
  logic              have_pend, have_pend_next;
  logic [ID_W-1:0]   pend_id, pend_id_next;
  logic              chg, chg_next;
  logic              drop, drop_next;
  logic [TIME_W-1:0] front, front_next;
  logic              out_valid, out_valid_next;
  tdq_result_t       res, res_next;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  tdq_entry_t        rd_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  tdq_entry_t        wr_data;

  logic out_free;
  logic due;
  logic pop_ok;
  logic shift_up;

  assign out_free = !out_valid || rsp.ready;
  assign due      = (rd_data.deadline <= tv) && (n_pop != POP_MAX);
  assign pop_ok   = !have_pend || out_free;
  assign shift_up = rd_data.deadline > tv;

  assign cmd.ready = (state == ST_IDLE);

  assign rsp.valid            = out_valid;
  assign rsp.expired_id       = res.expired_id;
  assign rsp.expired_valid    = res.expired_valid;
  assign rsp.last             = res.last;
  assign rsp.new_earliest     = res.new_earliest;
  assign rsp.deadline_valid   = res.deadline_valid;
  assign rsp.next_deadline    = res.next_deadline;
  assign rsp.insert_dropped   = res.insert_dropped;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          if (tdq_action_t'(cmd.action) == ACT_EXPIRE) begin
            state_next = ST_EXP_RD;
          end else if (count == DEPTH_CNT) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_INS_RD;
          end
        end
      end
      ST_INS_RD: begin
        state_next = (slot == '0) ? ST_FINISH : ST_INS_CMP;
      end
      ST_INS_CMP: begin
        state_next = shift_up ? ST_INS_RD : ST_FINISH;
      end
      ST_EXP_RD: begin
        state_next = (count == '0) ? ST_FINISH : ST_EXP_CMP;
      end
      ST_EXP_CMP: begin
        if (!due) begin
          state_next = ST_FINISH;
        end else if (pop_ok) begin
          state_next = ST_EXP_RD;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    head_next      = head;
    count_next     = count;
    slot_next      = slot;
    tv_next        = tv;
    tid_next       = tid;
    n_pop_next     = n_pop;
    have_pend_next = have_pend;
    pend_id_next   = pend_id;
    chg_next       = chg;
    drop_next      = drop;
    front_next     = front;
    out_valid_next = out_valid && !rsp.ready;
    res_next       = res;
    rd_en          = 1'b0;
    rd_addr        = head;
    wr_en          = 1'b0;
    wr_addr        = slot_addr(head, slot);
    wr_data        = '{deadline: tv, id: tid};

    unique case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          tv_next        = cmd.time_value;
          tid_next       = cmd.timer_id;
          slot_next      = count;
          n_pop_next     = '0;
          have_pend_next = 1'b0;
          chg_next       = 1'b0;
          drop_next      = (tdq_action_t'(cmd.action) == ACT_INSERT) &&
                           (count == DEPTH_CNT);
        end
      end
      ST_INS_RD: begin
        if (slot == '0) begin
          // new timer lands at the head
          wr_en      = 1'b1;
          count_next = count + CNT_W'(1);
          chg_next   = 1'b1;
          front_next = tv;
        end else begin
          rd_en   = 1'b1;
          rd_addr = slot_addr(head, slot - CNT_W'(1));
        end
      end
      ST_INS_CMP: begin
        wr_en = 1'b1;
        if (shift_up) begin
          // move the later entry one slot toward the tail
          wr_data   = rd_data;
          slot_next = slot - CNT_W'(1);
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      ST_EXP_RD: begin
        rd_en = (count != '0);
      end
      ST_EXP_CMP: begin
        front_next = rd_data.deadline;
        if (due && pop_ok) begin
          if (have_pend) begin
            out_valid_next = 1'b1;
            res_next       = '{expired_id: pend_id, expired_valid: 1'b1,
                               last: 1'b0, new_earliest: 1'b0,
                               deadline_valid: 1'b0, next_deadline: '0,
                               insert_dropped: 1'b0};
          end
          have_pend_next = 1'b1;
          pend_id_next   = rd_data.id;
          head_next      = (head == LAST_IDX) ? '0 : head + IDX_W'(1);
          count_next     = count - CNT_W'(1);
          n_pop_next     = n_pop + POP_W'(1);
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          res_next       = '{expired_id: have_pend ? pend_id : '0,
                             expired_valid: have_pend,
                             last: 1'b1,
                             new_earliest: chg,
                             deadline_valid: (count != '0),
                             next_deadline: (count != '0) ? front : '0,
                             insert_dropped: drop};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    slot      <= slot_next;
    tv        <= tv_next;
    tid       <= tid_next;
    n_pop     <= n_pop_next;
    have_pend <= have_pend_next;
    pend_id   <= pend_id_next;
    chg       <= chg_next;
    drop      <= drop_next;
    front     <= front_next;
    res       <= res_next;
  end

endmodule

/* bench/timer_deadline_queue_core_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for timer_deadline_queue_core: directed table, then random traffic.
// Depends on tdq_pkg, tdq_cmd_if, tdq_rsp_if and the core itself.
module timer_deadline_queue_core_tb;
  import tdq_pkg::*;

  localparam int DEPTH          = QUEUE_DEPTH_D;
  localparam int RAND_PER_PHASE = 119;
  localparam int LONG_HOLD      = 400;
  localparam int TAIL_CYCLES    = 100;
  localparam int CYCLE_LIMIT    = 500000;
  localparam int PRINT_CAP      = 40;

  typedef struct {
    tdq_action_t       act;
    logic [TIME_W-1:0] tv;
    logic [ID_W-1:0]   id;
    bit                typed;
    tdq_result_t       want;
  } timer_cmd_t;

  logic clk;
  logic rst;

  tdq_cmd_if cmd_ch ();
  tdq_rsp_if rsp_ch ();

  timer_deadline_queue_core #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // Mirror of the timer store
  logic [TIME_W-1:0] q_dl [DEPTH];
  logic [ID_W-1:0]   q_id [DEPTH];
  int                q_count;

  tdq_result_t awaited_results[$];
  timer_cmd_t  directed_cmds[$];

  int          n_errors;
  int          n_items;
  int          n_beats;
  int          n_dropped;
  int          n_expired;
  int          max_burst;
  int          send_idle_pct;
  int          rcv_idle_pct;
  bit          hold_req;
  int unsigned cycles;

  logic [TIME_W-1:0] sim_now;
  logic [TIME_W-1:0] last_ins_dl;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= PRINT_CAP)
      $display("[%0t] mismatch on result beat %0d: %s", $time, n_beats, msg);
  endtask

  // Build a result beat from the store as it stands now
  function automatic tdq_result_t beat_of(logic [ID_W-1:0] id, bit idv, bit lst, bit chg,
                                          bit drop);
    tdq_result_t r;
    r = '0;
    r.expired_id       = id;
    r.expired_valid    = idv;
    r.last             = lst;
    r.new_earliest     = chg;
    if (lst && q_count > 0) begin
      r.deadline_valid = 1'b1;
      r.next_deadline  = q_dl[0];
    end
    r.insert_dropped   = drop;
    return r;
  endfunction

  function automatic tdq_result_t closing_beat(bit chg, bit dv, logic [TIME_W-1:0] nd,
                                               bit drop);
    tdq_result_t r;
    r = '0;
    r.last             = 1'b1;
    r.new_earliest     = chg;
    r.deadline_valid   = dv;
    r.next_deadline    = nd;
    r.insert_dropped   = drop;
    return r;
  endfunction

  function automatic timer_cmd_t mk_cmd(tdq_action_t act, logic [TIME_W-1:0] tv,
                                        logic [ID_W-1:0] id, bit typed, tdq_result_t want);
    timer_cmd_t c;
    c.act   = act;
    c.tv    = tv;
    c.id    = id;
    c.typed = typed;
    c.want  = want;
    return c;
  endfunction

  // Append a beat to the list of awaited results
  function automatic void await_beat(tdq_result_t r);
    awaited_results.insert(awaited_results.size(), r);
  endfunction

  // Append a row to the directed table
  function automatic void add_row(timer_cmd_t c);
    directed_cmds.insert(directed_cmds.size(), c);
  endfunction

  // Apply one accepted command to the store and queue the beats it causes
  function automatic void predict_queue_step(tdq_action_t act, logic [TIME_W-1:0] tv,
                                             logic [ID_W-1:0] tid);
    logic [ID_W-1:0] ids [MAX_RESULTS];
    bit              chg;
    int              pos;
    int              popped;
    if (act == ACT_INSERT) begin
      if (q_count >= DEPTH) begin
        await_beat(beat_of('0, 1'b0, 1'b1, 1'b0, 1'b1));
        n_dropped++;
      end else begin
        chg = (q_count == 0) || (tv < q_dl[0]);
        // equal deadlines keep arrival order: go behind them
        pos = 0;
        while (pos < q_count && q_dl[pos] <= tv) pos++;
        for (int i = q_count; i > pos; i--) begin
          q_dl[i] = q_dl[i-1];
          q_id[i] = q_id[i-1];
        end
        q_dl[pos] = tv;
        q_id[pos] = tid;
        q_count++;
        await_beat(beat_of('0, 1'b0, 1'b1, chg, 1'b0));
      end
    end else begin
      popped = 0;
      while (popped < q_count && popped < MAX_RESULTS && q_dl[popped] <= tv) popped++;
      if (popped == 0) begin
        await_beat(beat_of('0, 1'b0, 1'b1, 1'b0, 1'b0));
      end else begin
        for (int i = 0; i < popped; i++) ids[i] = q_id[i];
        for (int i = popped; i < q_count; i++) begin
          q_dl[i-popped] = q_dl[i];
          q_id[i-popped] = q_id[i];
        end
        q_count -= popped;
        for (int i = 0; i < popped; i++)
          await_beat(beat_of(ids[i], 1'b1, i == popped - 1, 1'b0, 1'b0));
        n_expired += popped;
        if (popped > max_burst) max_burst = popped;
      end
    end
  endfunction

  // Random command: mostly deadlines near a moving "now", some ties, some far out
  function automatic timer_cmd_t draw_cmd(int ins_pct);
    timer_cmd_t c;
    int         r;
    c = mk_cmd(ACT_INSERT, '0, '0, 1'b0, '0);
    c.id = ID_W'($urandom);
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < ins_pct) begin
      c.act = ACT_INSERT;
      if (r < 10)      c.tv = TIME_W'({$urandom, $urandom});
      else if (r < 22) c.tv = last_ins_dl;
      else             c.tv = sim_now + $urandom_range(0, 300);
      last_ins_dl = c.tv;
    end else begin
      c.act = ACT_EXPIRE;
      if (r < 4)       c.tv = '1;
      else if (r < 10) c.tv = TIME_W'({$urandom, $urandom});
      else begin
        sim_now = sim_now + $urandom_range(0, 120);
        c.tv    = sim_now;
      end
    end
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  // Valid stays high on return so back-to-back beats need no extra toggle.
  task automatic send_cmd(input timer_cmd_t c);
    int base;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.action     <= c.act;
    cmd_ch.time_value <= c.tv;
    cmd_ch.timer_id   <= c.id;
    @(posedge clk);
    while (cmd_ch.ready !== 1'b1) @(posedge clk);
    n_items++;
    base = awaited_results.size();
    predict_queue_step(c.act, c.tv, c.id);
    if (c.typed) begin
      while (awaited_results.size() > base)
        awaited_results.delete(awaited_results.size() - 1);
      await_beat(c.want);
    end
    @(negedge clk);
  endtask

  task automatic check_result_beat();
    tdq_result_t want;
    n_beats++;
    if (awaited_results.size() == 0) begin
      report_mismatch("result beat with nothing awaited");
      return;
    end
    want = awaited_results.pop_front();
    if (rsp_ch.expired_id !== want.expired_id)
      report_mismatch($sformatf("expired_id %h, want %h", rsp_ch.expired_id,
                                want.expired_id));
    if (rsp_ch.expired_valid !== want.expired_valid)
      report_mismatch($sformatf("expired_valid %b, want %b", rsp_ch.expired_valid,
                                want.expired_valid));
    if (rsp_ch.last !== want.last)
      report_mismatch($sformatf("last %b, want %b", rsp_ch.last, want.last));
    if (rsp_ch.new_earliest !== want.new_earliest)
      report_mismatch($sformatf("new_earliest %b, want %b", rsp_ch.new_earliest,
                                want.new_earliest));
    if (rsp_ch.deadline_valid !== want.deadline_valid)
      report_mismatch($sformatf("deadline_valid %b, want %b", rsp_ch.deadline_valid,
                                want.deadline_valid));
    if (rsp_ch.next_deadline !== want.next_deadline)
      report_mismatch($sformatf("next_deadline %h, want %h", rsp_ch.next_deadline,
                                want.next_deadline));
    if (rsp_ch.insert_dropped !== want.insert_dropped)
      report_mismatch($sformatf("insert_dropped %b, want %b", rsp_ch.insert_dropped,
                                want.insert_dropped));
  endtask

  always @(posedge clk) begin
    if (rst === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      check_result_beat();
  end

  // Result sink: random stalls, plus one long hold on request
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left    = 0;
    hold_taken   = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_left  = LONG_HOLD;
        hold_taken = 1'b1;
      end
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("cycle limit of %0d reached with %0d results outstanding", CYCLE_LIMIT,
             awaited_results.size());
    $display("** timer_deadline_queue_core: FAILED **");
    $finish;
  end

  initial begin
    int ins_pct;
    rst               = 1'b1;
    cmd_ch.valid      = 1'b0;
    cmd_ch.action     = ACT_INSERT;
    cmd_ch.time_value = '0;
    cmd_ch.timer_id   = '0;
    hold_req          = 1'b0;
    q_count           = 0;
    n_errors          = 0;
    n_items           = 0;
    n_beats           = 0;
    n_dropped         = 0;
    n_expired         = 0;
    max_burst         = 0;
    send_idle_pct     = 20;
    rcv_idle_pct      = 60;
    sim_now           = '0;
    last_ins_dl       = '0;
    ins_pct           = 60;

    // Empty store, extremes of time and id, ties, nothing due
    add_row(mk_cmd(ACT_EXPIRE, '0, '0, 1'b1, closing_beat(1'b0, 1'b0, '0, 1'b0)));
    add_row(mk_cmd(ACT_INSERT, '1, '1, 1'b1, closing_beat(1'b1, 1'b1, '1, 1'b0)));
    add_row(mk_cmd(ACT_INSERT, '0, '0, 1'b1, closing_beat(1'b1, 1'b1, '0, 1'b0)));
    add_row(mk_cmd(ACT_INSERT, '0, 16'h0001, 1'b0, '0));
    add_row(mk_cmd(ACT_INSERT, 48'd7, 16'h0005, 1'b0, '0));
    add_row(mk_cmd(ACT_EXPIRE, '0, 16'h1234, 1'b0, '0));
    add_row(mk_cmd(ACT_EXPIRE, 48'd6, '0, 1'b0, '0));
    // Fill to capacity with mixed order, ties and far deadlines
    add_row(mk_cmd(ACT_INSERT, 48'd3000, 16'h0010, 1'b0, '0));
    add_row(mk_cmd(ACT_INSERT, 48'd2000, 16'h0011, 1'b0, '0));
    add_row(mk_cmd(ACT_INSERT, 48'd2000, 16'h0012, 1'b0, '0));
    add_row(mk_cmd(ACT_INSERT, 48'd7, 16'h0013, 1'b0, '0));
    add_row(mk_cmd(ACT_INSERT, 48'd1, 16'h0014, 1'b0, '0));
    add_row(mk_cmd(ACT_INSERT, 48'h8000_0000_0000, 16'h8015, 1'b0, '0));
    add_row(mk_cmd(ACT_INSERT, 48'd500, 16'h0016, 1'b0, '0));
    add_row(mk_cmd(ACT_INSERT, 48'd500, 16'h0017, 1'b0, '0));
    add_row(mk_cmd(ACT_INSERT, 48'd2500, 16'h0018, 1'b0, '0));
    add_row(mk_cmd(ACT_INSERT, 48'd10, 16'h0019, 1'b0, '0));
    add_row(mk_cmd(ACT_INSERT, 48'd7, 16'h001a, 1'b0, '0));
    add_row(mk_cmd(ACT_INSERT, 48'd999999, 16'h001b, 1'b0, '0));
    add_row(mk_cmd(ACT_INSERT, 48'hffff_ffff_fffe, 16'h001c, 1'b0, '0));
    add_row(mk_cmd(ACT_INSERT, 48'd20, 16'h001d, 1'b0, '0));
    // Full store: an earlier deadline is still refused and changes nothing
    add_row(mk_cmd(ACT_INSERT, '0, 16'haaaa, 1'b1,
                   closing_beat(1'b0, 1'b1, 48'd1, 1'b1)));
    // Drain all sixteen in one expire, then expire on an empty store
    add_row(mk_cmd(ACT_EXPIRE, '1, 16'hffff, 1'b0, '0));
    add_row(mk_cmd(ACT_EXPIRE, '1, '0, 1'b1, closing_beat(1'b0, 1'b0, '0, 1'b0)));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_cmds[i]) send_cmd(directed_cmds[i]);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 20;
          rcv_idle_pct  = 60;
        end
        1: begin
          send_idle_pct = 60;
          rcv_idle_pct  = 20;
        end
        default: begin
          send_idle_pct = 0;
          rcv_idle_pct  = 0;
        end
      endcase
      // restart "now" somewhere random, sometimes right below the wrap point
      if ($urandom_range(0, 2) == 0) sim_now = '1 - $urandom_range(0, 2000);
      else                           sim_now = TIME_W'({$urandom, $urandom});
      last_ins_dl = sim_now;
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        if (k % 32 == 0) begin
          case ($urandom_range(0, 2))
            0:       ins_pct = 35;
            1:       ins_pct = 60;
            default: ins_pct = 85;
          endcase
        end
        if (ph == 0 && k == 40) hold_req = 1'b1;
        if (ph == 1 && k == 60) begin
          // pause the sender until the block has returned everything
          cmd_ch.valid <= 1'b0;
          while (awaited_results.size() != 0) @(negedge clk);
        end
        send_cmd(draw_cmd(ins_pct));
      end
    end

    cmd_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("run covered %0d commands and %0d result beats in %0d cycles", n_items,
             n_beats, cycles);
    $display("timers expired %0d, largest single pop %0d, inserts refused when full %0d",
             n_expired, max_burst, n_dropped);
    if (n_errors == 0)
      $display("** timer_deadline_queue_core: PASSED **");
    else
      $display("** timer_deadline_queue_core: FAILED **");
    $finish;
  end

endmodule
